FILE: rtl/lau_pkg.sv
// shared types, widths and the arctangent table of the look-at angle unit
`default_nettype none
package lau_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int NORM_BITS       = 30;
    localparam int SQ_W            = 62;
    localparam int SQRT_CELLS      = 31;
    localparam int ROOT_W          = 31;
    localparam int CX_W            = 34;
    localparam int ANG_W           = 26;
    localparam int PITCH_W         = 24;
    localparam int CORDIC_STEPS    = 23;
    localparam int PRE_TARGET      = 29;
    localparam int PRE_SH_W        = 5;
    localparam logic signed [ANG_W-1:0] DEG_90  = ANG_W'(90 * 65536);
    localparam logic signed [ANG_W-1:0] DEG_180 = ANG_W'(180 * 65536);

    typedef struct packed {
        logic [NORM_BITS-1:0] ax;
        logic [NORM_BITS-1:0] ay;
        logic [NORM_BITS-1:0] az;
        logic                 nx;
        logic                 ny;
        logic                 nz;
        logic                 degen;
    } lau_side_t;

    typedef struct packed {
        logic dz_neg;
        logic dy_pos;
        logic dy_neg;
        logic degen;
    } lau_flags_t;

    typedef struct packed {
        logic signed [CX_W-1:0]  x;
        logic signed [CX_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } lau_vec_t;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0: v = ANG_W'(2949120);
            1: v = ANG_W'(1740967);
            2: v = ANG_W'(919879);
            3: v = ANG_W'(466945);
            4: v = ANG_W'(234379);
            5: v = ANG_W'(117304);
            6: v = ANG_W'(58666);
            7: v = ANG_W'(29335);
            8: v = ANG_W'(14668);
            9: v = ANG_W'(7334);
            10: v = ANG_W'(3667);
            11: v = ANG_W'(1833);
            12: v = ANG_W'(917);
            13: v = ANG_W'(458);
            14: v = ANG_W'(229);
            15: v = ANG_W'(115);
            16: v = ANG_W'(57);
            17: v = ANG_W'(29);
            18: v = ANG_W'(14);
            19: v = ANG_W'(7);
            20: v = ANG_W'(4);
            21: v = ANG_W'(2);
            22: v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // left shift that brings the larger operand up to bit 29
    function automatic logic [PRE_SH_W-1:0] prenorm_shift(input logic [ROOT_W-1:0] m);
        int p;
        p = 0;
        for (int b = 0; b < ROOT_W; b++)
        begin
            if (m[b])
                p = b;
        end
        if (p >= PRE_TARGET)
            return '0;
        return PRE_SH_W'(PRE_TARGET - p);
    endfunction

    function automatic logic signed [ANG_W-1:0] clamp90(input logic signed [ANG_W-1:0] z);
        if (z > DEG_90)
            return DEG_90;
        if (z < -DEG_90)
            return -DEG_90;
        return z;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/lau_in_if.sv
// point pair channel
`default_nettype none
interface lau_in_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] from_x;
    logic signed [COORD_WIDTH-1:0] from_y;
    logic signed [COORD_WIDTH-1:0] from_z;
    logic signed [COORD_WIDTH-1:0] to_x;
    logic signed [COORD_WIDTH-1:0] to_y;
    logic signed [COORD_WIDTH-1:0] to_z;
    modport source (output valid, from_x, from_y, from_z, to_x, to_y, to_z, input ready);
    modport sink (input valid, from_x, from_y, from_z, to_x, to_y, to_z, output ready);
endinterface
`default_nettype wire

FILE: rtl/lau_out_if.sv
// angle result channel
`default_nettype none
interface lau_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] pitch_deg;
    logic signed [25:0] yaw_deg;
    logic               degenerate;
    modport source (output valid, pitch_deg, yaw_deg, degenerate, input ready);
    modport sink (input valid, pitch_deg, yaw_deg, degenerate, output ready);
endinterface
`default_nettype wire

FILE: rtl/lau_sqrt_cell.sv
// one bit of the pipelined integer square root
`default_nettype none
module lau_sqrt_cell
    import lau_pkg::*;
#(
    parameter int BIT_EXP = 60
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            valid_in,
    input  wire logic [SQ_W-1:0] n_in,
    input  wire logic [SQ_W-1:0] res_in,
    input  wire lau_side_t       side_in,
    output logic                 valid_reg,
    output logic [SQ_W-1:0]      n_reg,
    output logic [SQ_W-1:0]      res_reg,
    output lau_side_t            side_reg
);
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << BIT_EXP;

    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] n_next;
    logic [SQ_W-1:0] res_next;

    always_comb
    begin
        trial = res_in + BIT;
        if (n_in >= trial)
        begin
            n_next   = n_in - trial;
            res_next = (res_in >> 1) + BIT;
        end
        else
        begin
            n_next   = n_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_next;
            res_reg  <= res_next;
            side_reg <= side_in;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/lau_cordic_cell.sv
// one vectoring step for the pitch and yaw rotators side by side
`default_nettype none
module lau_cordic_cell
    import lau_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       valid_in,
    input  wire lau_vec_t   pitch_in,
    input  wire lau_vec_t   yaw_in,
    input  wire lau_flags_t flags_in,
    output logic            valid_reg,
    output lau_vec_t        pitch_reg,
    output lau_vec_t        yaw_reg,
    output lau_flags_t      flags_reg
);
    function automatic lau_vec_t rotate(input lau_vec_t v);
        lau_vec_t r;
        logic signed [CX_W-1:0] xs;
        logic signed [CX_W-1:0] ys;
        xs = v.x >>> STEP;
        ys = v.y >>> STEP;
        if (!v.y[CX_W-1])
        begin
            r.x = v.x + ys;
            r.y = v.y - xs;
            r.z = v.z + atan_entry(STEP);
        end
        else
        begin
            r.x = v.x - ys;
            r.y = v.y + xs;
            r.z = v.z - atan_entry(STEP);
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_reg <= rotate(pitch_in);
            yaw_reg   <= rotate(yaw_in);
            flags_reg <= flags_in;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/look_at_angle_unit.sv
// look-at angle unit: pitch and yaw from an origin point toward a target point
//
// points is a valid/ready sink carrying from_x..to_z in signed fixed point;
// angles is a valid/ready source carrying pitch_deg (negated pitch), yaw_deg
// and degenerate, pitch_deg in signed Q8.16 and yaw_deg in signed Q10.16 degrees.
// one point pair is taken every cycle while points.ready is high, and each
// gives exactly one result after passing the difference, scaling and
// squaring stages, 31 square root cells (one root bit each), the operand
// scaling stages and 23 arctangent cells, then the output register.
// throughput is one item per cycle while the receiver does not stall, set by
// the row of cells which all move together on a common enable.
// when the receiver stalls with a result held in the output register, the
// whole pipeline freezes and points.ready drops in the same cycle; it rises
// again as soon as the held result is taken.
// reset clears every stage valid bit and the output valid; no clearing pass
// is needed and the first pair can be taken right after reset.
`default_nettype none
module look_at_angle_unit
    import lau_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lau_in_if.sink    points,
    lau_out_if.source angles
);
    localparam int DW   = COORD_WIDTH + 1;
    localparam int SH_W = $clog2(DW + 1);

    logic adv;

    logic            v0_reg;
    logic [DW-1:0]   mx_reg, my_reg, mz_reg;
    logic            nx0_reg, ny0_reg, nz0_reg;
    logic            v1_reg;
    logic [DW-1:0]   mx1_reg, my1_reg, mz1_reg;
    logic            nx1_reg, ny1_reg, nz1_reg;
    logic [SH_W-1:0] r_reg;
    logic [SH_W-1:0] r_next;
    logic            v2_reg;
    lau_side_t       side2_reg, side2_next;
    logic            v3_reg;
    lau_side_t       side3_reg;
    logic [2*NORM_BITS-1:0] sqx_reg, sqz_reg;
    logic            v4_reg;
    lau_side_t       side4_reg;
    logic [SQ_W-1:0] sum_reg;

    logic signed [DW-1:0] dx, dy, dz;

    always_comb
    begin
        dx = $signed({points.to_x[COORD_WIDTH-1], points.to_x})
           - $signed({points.from_x[COORD_WIDTH-1], points.from_x});
        dy = $signed({points.to_y[COORD_WIDTH-1], points.to_y})
           - $signed({points.from_y[COORD_WIDTH-1], points.from_y});
        dz = $signed({points.to_z[COORD_WIDTH-1], points.to_z})
           - $signed({points.from_z[COORD_WIDTH-1], points.from_z});
    end

    // common scaling so the largest magnitude stays below 2^30
    always_comb
    begin
        logic [DW-1:0] top;
        int len;
        int r;
        top = mx_reg | my_reg | mz_reg;
        len = 0;
        for (int b = 0; b < DW; b++)
        begin
            if (top[b])
                len = b + 1;
        end
        r = (len > NORM_BITS) ? len - NORM_BITS : 0;
        r_next = SH_W'(r);
    end

    always_comb
    begin
        logic [DW-1:0] sx, sy, sz;
        sx = mx1_reg >> r_reg;
        sy = my1_reg >> r_reg;
        sz = mz1_reg >> r_reg;
        side2_next.ax    = sx[NORM_BITS-1:0];
        side2_next.ay    = sy[NORM_BITS-1:0];
        side2_next.az    = sz[NORM_BITS-1:0];
        side2_next.nx    = nx1_reg;
        side2_next.ny    = ny1_reg;
        side2_next.nz    = nz1_reg;
        side2_next.degen = (sx[NORM_BITS-1:0] == '0) && (sz[NORM_BITS-1:0] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= points.valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx0_reg   <= dx[DW-1];
            ny0_reg   <= dy[DW-1];
            nz0_reg   <= dz[DW-1];
            mx_reg    <= dx[DW-1] ? DW'(-dx) : DW'(dx);
            my_reg    <= dy[DW-1] ? DW'(-dy) : DW'(dy);
            mz_reg    <= dz[DW-1] ? DW'(-dz) : DW'(dz);
            mx1_reg   <= mx_reg;
            my1_reg   <= my_reg;
            mz1_reg   <= mz_reg;
            nx1_reg   <= nx0_reg;
            ny1_reg   <= ny0_reg;
            nz1_reg   <= nz0_reg;
            r_reg     <= r_next;
            side2_reg <= side2_next;
            side3_reg <= side2_reg;
            sqx_reg   <= side2_reg.ax * side2_reg.ax;
            sqz_reg   <= side2_reg.az * side2_reg.az;
            side4_reg <= side3_reg;
            sum_reg   <= SQ_W'(sqx_reg) + SQ_W'(sqz_reg);
        end
    end

    // square root row
    logic            sv [SQRT_CELLS+1];
    logic [SQ_W-1:0] sn [SQRT_CELLS+1];
    logic [SQ_W-1:0] sr [SQRT_CELLS+1];
    lau_side_t       ss [SQRT_CELLS+1];

    assign sv[0] = v4_reg;
    assign sn[0] = sum_reg;
    assign sr[0] = '0;
    assign ss[0] = side4_reg;

    for (genvar k = 0; k < SQRT_CELLS; k++)
    begin : g_sqrt
        lau_sqrt_cell #(.BIT_EXP(2 * (SQRT_CELLS - 1 - k))) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (sv[k]),
            .n_in      (sn[k]),
            .res_in    (sr[k]),
            .side_in   (ss[k]),
            .valid_reg (sv[k+1]),
            .n_reg     (sn[k+1]),
            .res_reg   (sr[k+1]),
            .side_reg  (ss[k+1])
        );
    end

    // operand scaling ahead of the arctangent row
    lau_side_t sq_side;
    logic [ROOT_W-1:0] h;
    logic            pa_valid_reg;
    logic [PRE_SH_W-1:0] ps_reg, ys_reg;
    lau_vec_t        pa_pitch_reg, pa_yaw_reg;
    lau_flags_t      pa_flags_reg;
    logic            pb_valid_reg;
    lau_vec_t        pb_pitch_reg, pb_yaw_reg;
    lau_flags_t      pb_flags_reg;
    lau_flags_t      flags_next;
    lau_vec_t        pitch_vec, yaw_vec;

    always_comb
    begin
        sq_side = ss[SQRT_CELLS];
        h = sr[SQRT_CELLS][ROOT_W-1:0];
        pitch_vec.x = CX_W'(h);
        pitch_vec.y = sq_side.ny ? -CX_W'(sq_side.ay) : CX_W'(sq_side.ay);
        pitch_vec.z = '0;
        yaw_vec.x   = CX_W'(sq_side.az);
        yaw_vec.y   = sq_side.nx ? -CX_W'(sq_side.ax) : CX_W'(sq_side.ax);
        yaw_vec.z   = '0;
        flags_next.dz_neg = sq_side.nz && (sq_side.az != '0);
        flags_next.dy_pos = !sq_side.ny && (sq_side.ay != '0);
        flags_next.dy_neg = sq_side.ny && (sq_side.ay != '0);
        flags_next.degen  = sq_side.degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_valid_reg <= 1'b0;
            pb_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            pa_valid_reg <= sv[SQRT_CELLS];
            pb_valid_reg <= pa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ps_reg         <= prenorm_shift(h | ROOT_W'(sq_side.ay));
            ys_reg         <= prenorm_shift(ROOT_W'(sq_side.az | sq_side.ax));
            pa_pitch_reg   <= pitch_vec;
            pa_yaw_reg     <= yaw_vec;
            pa_flags_reg   <= flags_next;
            pb_pitch_reg.x <= pa_pitch_reg.x <<< ps_reg;
            pb_pitch_reg.y <= pa_pitch_reg.y <<< ps_reg;
            pb_pitch_reg.z <= pa_pitch_reg.z;
            pb_yaw_reg.x   <= pa_yaw_reg.x <<< ys_reg;
            pb_yaw_reg.y   <= pa_yaw_reg.y <<< ys_reg;
            pb_yaw_reg.z   <= pa_yaw_reg.z;
            pb_flags_reg   <= pa_flags_reg;
        end
    end

    // arctangent row
    logic       cv [CORDIC_STEPS+1];
    lau_vec_t   cp [CORDIC_STEPS+1];
    lau_vec_t   cy [CORDIC_STEPS+1];
    lau_flags_t cf [CORDIC_STEPS+1];

    assign cv[0] = pb_valid_reg;
    assign cp[0] = pb_pitch_reg;
    assign cy[0] = pb_yaw_reg;
    assign cf[0] = pb_flags_reg;

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        lau_cordic_cell #(.STEP(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .valid_in  (cv[k]),
            .pitch_in  (cp[k]),
            .yaw_in    (cy[k]),
            .flags_in  (cf[k]),
            .valid_reg (cv[k+1]),
            .pitch_reg (cp[k+1]),
            .yaw_reg   (cy[k+1]),
            .flags_reg (cf[k+1])
        );
    end

    // final selection and output register
    lau_flags_t fl;
    logic signed [ANG_W-1:0] pitch_sel, yaw_sel, yaw_c;
    logic                    out_valid_reg;
    logic signed [PITCH_W-1:0] pitch_out_reg;
    logic signed [ANG_W-1:0]   yaw_out_reg;
    logic                      degen_out_reg;

    always_comb
    begin
        fl = cf[CORDIC_STEPS];
        yaw_c = clamp90(cy[CORDIC_STEPS].z);
        if (fl.degen)
        begin
            yaw_sel = '0;
            if (fl.dy_pos)
                pitch_sel = DEG_90;
            else if (fl.dy_neg)
                pitch_sel = -DEG_90;
            else
                pitch_sel = '0;
        end
        else
        begin
            pitch_sel = clamp90(cp[CORDIC_STEPS].z);
            yaw_sel   = fl.dz_neg ? (-DEG_180 - yaw_c) : yaw_c;
        end
    end

    assign adv = !out_valid_reg || angles.ready;
    assign points.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= cv[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pitch_out_reg <= PITCH_W'(-pitch_sel);
            yaw_out_reg   <= yaw_sel;
            degen_out_reg <= fl.degen;
        end
    end

    assign angles.valid      = out_valid_reg;
    assign angles.pitch_deg  = pitch_out_reg;
    assign angles.yaw_deg    = yaw_out_reg;
    assign angles.degenerate = degen_out_reg;

    a_degen_yaw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && degen_out_reg |-> yaw_out_reg == '0)
        else $error("degenerate result with nonzero yaw");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (pitch_out_reg <= PITCH_W'(DEG_90)) &&
                          (pitch_out_reg >= -PITCH_W'(DEG_90)))
        else $error("pitch outside ninety degrees");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(pb_valid_reg) && $stable(cv[CORDIC_STEPS]))
        else $error("pipeline moved during a stall");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (yaw_out_reg <= DEG_90) &&
                          (yaw_out_reg >= -DEG_180 - DEG_90))
        else $error("yaw outside its range");
endmodule
`default_nettype wire

FILE: test/lau_angle_checker.sv
// checker for the look-at angle unit: predicts every angle result and compares
`timescale 1ns / 1ps
module lau_angle_checker
    import lau_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    lau_in_if         points,
    lau_out_if        angles,
    output int        fails,
    output int        pending
);
    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ANG_W-1:0]   yaw;
        logic                      degen;
    } angle_res_t;

    angle_res_t awaited_angles[$];

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    // cordic vectoring as the unit does it, q.16 degrees
    function automatic longint cordic_atan(input longint y, input longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        while ((x < 0 ? -x : x) < (64'sd1 <<< 29) && (y < 0 ? -y : y) < (64'sd1 <<< 29))
        begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(atan_entry(i));
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(atan_entry(i));
            end
        end
        if (z > 90 * 65536)
            z = 90 * 65536;
        if (z < -90 * 65536)
            z = -90 * 65536;
        return z;
    endfunction

    function automatic longint floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic angle_res_t look_angles(input longint fx, input longint fy,
                                               input longint fz, input longint tx,
                                               input longint ty, input longint tz);
        longint diff[3];
        longint m[3];
        longint unsigned top;
        int len;
        int r;
        longint pitch;
        longint yaw;
        logic degen;
        angle_res_t res;
        diff[0] = tx - fx;
        diff[1] = ty - fy;
        diff[2] = tz - fz;
        top = 0;
        for (int k = 0; k < 3; k++)
            top = top | longint'(diff[k] < 0 ? -diff[k] : diff[k]);
        len = 0;
        while (len < 64 && (top >> len) != 0)
            len++;
        r = len > NORM_BITS ? len - NORM_BITS : 0;
        for (int k = 0; k < 3; k++)
        begin
            m[k] = (diff[k] < 0 ? -diff[k] : diff[k]) >> r;
            if (diff[k] < 0)
                m[k] = -m[k];
        end
        degen = (m[0] == 0 && m[2] == 0);
        if (degen)
        begin
            yaw = 0;
            pitch = m[1] > 0 ? 90 * 65536 : (m[1] < 0 ? -90 * 65536 : 0);
        end
        else
        begin
            pitch = cordic_atan(m[1], floor_sqrt(m[0] * m[0] + m[2] * m[2]));
            yaw = cordic_atan(m[0], m[2] < 0 ? -m[2] : m[2]);
            if (m[2] < 0)
                yaw = -180 * 65536 - yaw;
        end
        res.pitch = PITCH_W'(-pitch);
        res.yaw = ANG_W'(yaw);
        res.degen = degen;
        return res;
    endfunction

    initial
    begin
        fails = 0;
    end

    assign pending = awaited_angles.size();

    // sampled mid-cycle, when handshake and payload are settled for the coming edge
    always @(negedge clk)
    begin
        angle_res_t want;
        if (rst_n && points.valid && points.ready)
            awaited_angles.push_back(look_angles(points.from_x, points.from_y,
                                                 points.from_z, points.to_x,
                                                 points.to_y, points.to_z));
        if (rst_n && angles.valid && angles.ready)
        begin
            if (awaited_angles.size() == 0)
                report("unexpected result, pitch", angles.pitch_deg, 0);
            else
            begin
                want = awaited_angles.pop_front();
                if (angles.pitch_deg !== want.pitch)
                    report("pitch_deg", angles.pitch_deg, want.pitch);
                if (angles.yaw_deg !== want.yaw)
                    report("yaw_deg", angles.yaw_deg, want.yaw);
                if (angles.degenerate !== want.degen)
                    report("degenerate", angles.degenerate, want.degen);
            end
        end
    end
endmodule

FILE: test/tb_look_at_angle_unit.sv
// testbench top of the look-at angle unit: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module tb_look_at_angle_unit;
    import lau_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int TAIL_CYCLES  = 80;

    logic clk;
    logic rst_n;
    int   fails;
    int   pending;

    lau_in_if  #(.COORD_WIDTH(32)) points ();
    lau_out_if angles ();

    look_at_angle_unit #(.COORD_WIDTH(32)) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (points),
        .angles (angles)
    );

    lau_angle_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (points),
        .angles  (angles),
        .fails   (fails),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    int sent;

    // stretches of back-to-back traffic between stretches of random gaps
    function automatic int draw_gap(input int idx);
        if ((idx / 48) % 3 == 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    task automatic send_pair(input logic [31:0] fx, input logic [31:0] fy,
                             input logic [31:0] fz, input logic [31:0] tx,
                             input logic [31:0] ty, input logic [31:0] tz);
        int gap;
        logic took;
        gap = draw_gap(sent);
        if (gap > 0)
        begin
            points.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        points.valid  <= 1'b1;
        points.from_x <= fx;
        points.from_y <= fy;
        points.from_z <= fz;
        points.to_x   <= tx;
        points.to_y   <= ty;
        points.to_z   <= tz;
        do
        begin
            @(negedge clk);
            took = points.ready;
            @(posedge clk);
        end
        while (!took);
        sent++;
    endtask

    // coordinate near a base, so that differences stay small
    function automatic logic [31:0] near(input logic [31:0] base, input int span);
        return base + 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic random_pair();
        logic [31:0] f[3];
        logic [31:0] t[3];
        int kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++)
        begin
            f[k] = $urandom;
            t[k] = $urandom;
        end
        case (kind)
            0, 1, 2:
                for (int k = 0; k < 3; k++)
                    t[k] = near(f[k], $urandom_range(1, 1 << $urandom_range(0, 20)));
            3:
            begin
                t[0] = f[0];
                t[2] = f[2];
            end
            4:
                t[$urandom_range(0, 2)] = f[$urandom_range(0, 2)];
            5:
            begin
                t[0] = near(f[0], 1);
                t[2] = near(f[2], 1);
            end
            6:
                for (int k = 0; k < 3; k++)
                begin
                    f[k] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
                    t[k] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
                end
            default:
            begin
            end
        endcase
        send_pair(f[0], f[1], f[2], t[0], t[1], t[2]);
    endtask

    initial
    begin
        points.valid  <= 1'b0;
        points.from_x <= '0;
        points.from_y <= '0;
        points.from_z <= '0;
        points.to_x   <= '0;
        points.to_y   <= '0;
        points.to_z   <= '0;
        rst_n = 1'b0;
        sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // coinciding points, vertical both ways, near vertical
        send_pair(32'd5, 32'd7, 32'd9, 32'd5, 32'd7, 32'd9);
        send_pair(0, 0, 0, 0, 32'h0001_0000, 0);
        send_pair(0, 0, 0, 0, 32'hffff_0000, 0);
        send_pair(0, 32'h8000_0000, 0, 1, 32'h7fff_ffff, 0);
        send_pair(0, 32'h7fff_ffff, 0, 0, 32'h8000_0000, 1);
        // zero dz: yaw of plus or minus ninety
        send_pair(0, 0, 0, 32'h0001_0000, 0, 0);
        send_pair(0, 0, 0, 32'hffff_0000, 0, 0);
        send_pair(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0);
        // negative dz, mirrored yaw; then straight along positive z
        send_pair(0, 0, 0, 32'h0000_1000, 0, 32'hffff_0000);
        send_pair(0, 0, 0, 32'hffff_f000, 32'h0002_0000, 32'hffff_0000);
        send_pair(0, 0, 0, 0, 0, 32'hffff_0000);
        send_pair(0, 0, 0, 0, 0, 32'h0001_0000);
        // extremes of the fields, then unit differences
        send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_pair(32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_pair(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0);
        send_pair(0, 0, 0, 1, 1, 1);
        send_pair(0, 0, 0, 1, 0, 32'hffff_ffff);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            random_pair();
        points.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // receiver with random stalls between transfers
    initial
    begin
        int stall;
        int taken;
        logic took;
        angles.ready <= 1'b0;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_gap(taken + 17);
            if (stall > 0)
            begin
                angles.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            angles.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = angles.valid && angles.ready;
                @(posedge clk);
            end
            while (!took);
            taken++;
        end
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule
